@@ rtl/core/clock_page_replacement_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the clock page replacement block
// Shared concurrent assertion forms. They are sampled on the rising clock
// edge and disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef CLOCK_PAGE_REPLACEMENT_ASSERT_SVH
`define CLOCK_PAGE_REPLACEMENT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/cpr_pkg.sv @@
// ---------------------------------------------------------------------------
// Clock page replacement package
// Field widths, parameter defaults and the command and status groups that
// pass between the controller and the datapath.
// ---------------------------------------------------------------------------
package cpr_pkg;

  localparam int FRAMES_DEF    = 4;
  localparam int PAGE_BITS_DEF = 16;

  localparam int PAGE_W  = 16;
  localparam int FRAME_W = 2;
  localparam int COUNT_W = 32;

  // Commands from the controller, at most one raised in a cycle.
  typedef struct packed {
    logic load;
    logic look;
    logic update;
    logic sweep;
    logic finish;
  } cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic found;
    logic empty;
    logic use_at_hand;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/core/cpr_ctrl.sv @@
// ---------------------------------------------------------------------------
// Clock page replacement controller
// Sequences one request through lookup, update, hand sweep and result.
// ---------------------------------------------------------------------------
module cpr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cpr_pkg::stat_t stat,
  output cpr_pkg::cmd_t  cmd
);
  import cpr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOOK   = 5'b00010,
    S_UPDATE = 5'b00100,
    S_SWEEP  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look   = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        if (stat.found || stat.empty) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_SWEEP;
        end
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (!stat.use_at_hand) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/core/cpr_datapath.sv @@
// ---------------------------------------------------------------------------
// Clock page replacement datapath
// Frame table, use bits, clock hand, saturating totals and result register.
// ---------------------------------------------------------------------------
`include "clock_page_replacement_assert.svh"

module cpr_datapath #(
  parameter int FRAMES    = cpr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = cpr_pkg::PAGE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cpr_pkg::cmd_t               cmd,
  output cpr_pkg::stat_t              stat,
  input  logic [cpr_pkg::PAGE_W-1:0]  page_number,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic                        hit,
  output logic [cpr_pkg::FRAME_W-1:0] frame,
  output logic                        evicted,
  output logic [cpr_pkg::PAGE_W-1:0]  evicted_page,
  output logic [cpr_pkg::COUNT_W-1:0] hit_total,
  output logic [cpr_pkg::COUNT_W-1:0] request_total
);
  import cpr_pkg::*;

  localparam int IDX_W = $clog2(FRAMES);

  logic [PAGE_BITS-1:0] req_page;
  logic [PAGE_BITS-1:0] page_mem [FRAMES];
  logic [FRAMES-1:0]    valid_bits;
  logic [FRAMES-1:0]    use_bits;
  logic [IDX_W-1:0]     hand;
  logic [IDX_W-1:0]     hand_next;
  logic [COUNT_W-1:0]   hit_count;
  logic [COUNT_W-1:0]   req_count;
  logic                 found_q;
  logic                 empty_q;
  logic [IDX_W-1:0]     where_q;
  logic                 evict_q;
  logic [PAGE_BITS-1:0] old_page_q;

  logic                 found;
  logic                 empty_found;
  logic [IDX_W-1:0]     match_idx;
  logic [IDX_W-1:0]     empty_idx;

  // Parallel compare of every frame, lowest index wins.
  always_comb begin
    found       = 1'b0;
    empty_found = 1'b0;
    match_idx   = '0;
    empty_idx   = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (valid_bits[i] && (page_mem[i] == req_page)) begin
        found     = 1'b1;
        match_idx = IDX_W'(i);
      end
      if (!valid_bits[i]) begin
        empty_found = 1'b1;
        empty_idx   = IDX_W'(i);
      end
    end
  end

  assign hand_next = (hand == IDX_W'(FRAMES - 1)) ? '0 : hand + 1'b1;

  assign stat.found       = found_q;
  assign stat.empty       = empty_q;
  assign stat.use_at_hand = use_bits[hand];
  assign stat.out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      use_bits   <= '0;
      hand       <= '0;
      hit_count  <= '0;
      req_count  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.load) begin
        req_page <= PAGE_BITS'(page_number);
      end
      if (cmd.look) begin
        found_q    <= found;
        empty_q    <= empty_found;
        where_q    <= found ? match_idx : empty_idx;
        evict_q    <= 1'b0;
        old_page_q <= '0;
        req_count  <= (req_count == '1) ? req_count : req_count + 1'b1;
      end
      if (cmd.update) begin
        if (found_q) begin
          use_bits[where_q] <= 1'b1;
          hit_count         <= (hit_count == '1) ? hit_count : hit_count + 1'b1;
        end else if (empty_q) begin
          page_mem[where_q]   <= req_page;
          valid_bits[where_q] <= 1'b1;
          use_bits[where_q]   <= 1'b0;
        end
      end
      if (cmd.sweep) begin
        if (use_bits[hand]) begin
          use_bits[hand] <= 1'b0;
          hand           <= hand_next;
        end else begin
          where_q        <= hand;
          evict_q        <= 1'b1;
          old_page_q     <= page_mem[hand];
          page_mem[hand] <= req_page;
          use_bits[hand] <= 1'b0;
          hand           <= hand_next;
        end
      end
      if (cmd.finish) begin
        out_valid     <= 1'b1;
        hit           <= found_q;
        frame         <= FRAME_W'(where_q);
        evicted       <= evict_q;
        evicted_page  <= PAGE_W'(old_page_q);
        hit_total     <= hit_count;
        request_total <= req_count;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `CPR_ASSERT_NEXT(a_req_monotonic, clk, rst, 1'b1, req_count >= $past(req_count), "request total fell")
  `CPR_ASSERT_SAME(a_hits_bounded, clk, rst, 1'b1, hit_count <= req_count, "hits exceed requests")
  `CPR_ASSERT_NEXT(a_sweep_clears, clk, rst, cmd.sweep, !use_bits[$past(hand)], "sweep left use bit set")

endmodule

@@ rtl/core/clock_page_replacement.sv @@
// ---------------------------------------------------------------------------
// Clock page replacement
// Second chance page replacement over a fixed set of frames.
// ---------------------------------------------------------------------------
// One page request word is taken at a time. For a hit or a fill of an empty
// frame the block passes through four steps before it is ready again: it
// captures the request, compares it against every frame in parallel,
// updates the frame table and loads the result register. A miss with every
// frame full adds a hand sweep, in which the single clock hand inspects one
// use bit each cycle. The result word appears the cycle after it is loaded
// and waits in its register until taken; a held result only delays the next
// one, never the lookup. After reset every frame is empty, all use bits and
// both totals are zero and the hand points at frame zero. The totals
// saturate at their maximum.
// ---------------------------------------------------------------------------
module clock_page_replacement #(
  parameter int FRAMES    = cpr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = cpr_pkg::PAGE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cpr_pkg::PAGE_W-1:0]  page_number,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        hit,
  output logic [cpr_pkg::FRAME_W-1:0] frame,
  output logic                        evicted,
  output logic [cpr_pkg::PAGE_W-1:0]  evicted_page,
  output logic [cpr_pkg::COUNT_W-1:0] hit_total,
  output logic [cpr_pkg::COUNT_W-1:0] request_total
);
  import cpr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // The controller owns the sequencing; it sees the datapath only through
  // the command and status groups.
  cpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the frame table, the use bits, the hand, the totals
  // and the result register.
  cpr_datapath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .page_number   (page_number),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .hit           (hit),
    .frame         (frame),
    .evicted       (evicted),
    .evicted_page  (evicted_page),
    .hit_total     (hit_total),
    .request_total (request_total)
  );

endmodule

@@ bench/tb_clock_page_replacement.sv @@
// ---------------------------------------------------------------------------
// Testbench for the clock page replacement block
// Page request words go in over a valid/ready channel. Each result word is
// compared field by field with a second chance frame table kept alongside
// the block. A short typed sequence comes first. Random requests follow,
// drawn mostly from small page pools so that hits, fills and full sweeps
// all occur. Both sides insert random gaps, with steady stretches between.
// ---------------------------------------------------------------------------
module tb_clock_page_replacement;

  localparam int NUM_FRAMES  = cpr_pkg::FRAMES_DEF;
  localparam int PW          = cpr_pkg::PAGE_W;
  localparam int FW          = cpr_pkg::FRAME_W;
  localparam int CW          = cpr_pkg::COUNT_W;
  localparam int RANDOM_REQS = 1900;
  localparam int CYCLE_LIMIT = 200000;

  // One result word, in port order.
  typedef struct packed {
    logic          hit;
    logic [FW-1:0] frame;
    logic          evicted;
    logic [PW-1:0] evicted_page;
    logic [CW-1:0] hit_total;
    logic [CW-1:0] request_total;
  } lookup_t;

  // One row of the opening sequence. Where typed is set, the row carries a
  // result worked out by hand; otherwise the frame table below decides.
  typedef struct packed {
    logic [PW-1:0] page;
    logic          typed;
    lookup_t       want;
  } request_row_t;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_ready;
  logic [PW-1:0] page_number;
  logic          out_valid;
  logic          out_ready;
  logic          hit;
  logic [FW-1:0] frame;
  logic          evicted;
  logic [PW-1:0] evicted_page;
  logic [CW-1:0] hit_total;
  logic [CW-1:0] request_total;

  clock_page_replacement uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .page_number   (page_number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .frame         (frame),
    .evicted       (evicted),
    .evicted_page  (evicted_page),
    .hit_total     (hit_total),
    .request_total (request_total)
  );

  // The frame table as the block should hold it.
  logic [PW-1:0] resident_page [NUM_FRAMES];
  logic          frame_filled  [NUM_FRAMES];
  logic          second_chance [NUM_FRAMES];
  int            clock_hand;
  logic [CW-1:0] hits_so_far;
  logic [CW-1:0] requests_so_far;

  lookup_t      awaited_lookups[$];
  request_row_t opening_rows[$];
  int           mismatches = 0;
  int           cycle_count = 0;
  logic         steady_feed;
  logic         steady_drain;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Both totals stop at their maximum rather than wrapping.
  function automatic logic [CW-1:0] bump_total(input logic [CW-1:0] v);
    return (v == {CW{1'b1}}) ? v : v + 1'b1;
  endfunction

  // Apply one request to the frame table and return the result word it
  // should produce. A hit sets the use bit; a miss fills the lowest empty
  // frame, or else the hand sweeps, giving each used frame its second
  // chance, and replaces the first frame whose use bit is already clear.
  function automatic lookup_t replace_page(input logic [PW-1:0] page);
    lookup_t r;
    int      slot;
    int      empty_slot;
    logic    found;
    logic    have_empty;
    int      h;
    int      steps;
    found      = 1'b0;
    have_empty = 1'b0;
    slot       = 0;
    empty_slot = 0;
    r          = '0;
    requests_so_far = bump_total(requests_so_far);
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (frame_filled[i] && resident_page[i] == page && !found) begin
        found = 1'b1;
        slot  = i;
      end
      if (!frame_filled[i] && !have_empty) begin
        have_empty = 1'b1;
        empty_slot = i;
      end
    end
    if (found) begin
      second_chance[slot] = 1'b1;
      hits_so_far = bump_total(hits_so_far);
    end else if (have_empty) begin
      slot = empty_slot;
      resident_page[slot] = page;
      frame_filled[slot]  = 1'b1;
      second_chance[slot] = 1'b0;
    end else begin
      h = clock_hand;
      for (steps = 0; steps < NUM_FRAMES && second_chance[h]; steps++) begin
        second_chance[h] = 1'b0;
        h = (h + 1) % NUM_FRAMES;
      end
      slot = h;
      r.evicted      = 1'b1;
      r.evicted_page = resident_page[slot];
      resident_page[slot] = page;
      second_chance[slot] = 1'b0;
      clock_hand = (slot + 1) % NUM_FRAMES;
    end
    r.hit           = found;
    r.frame         = slot[FW-1:0];
    r.hit_total     = hits_so_far;
    r.request_total = requests_so_far;
    return r;
  endfunction

  // Offer one request word, entered and left at a falling edge. The frame
  // table is updated at the rising edge on which the word is taken.
  task automatic offer_page(input request_row_t row);
    int      gap;
    lookup_t predicted;
    gap = steady_feed ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    page_number <= row.page;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = replace_page(row.page);
    awaited_lookups.push_back(row.typed ? row.want : predicted);
    @(negedge clk);
  endtask

  // Stimulus: reset, the opening sequence, then random requests.
  initial begin : stimulus
    logic [PW-1:0] page_pool [8];
    int            pool_span;
    request_row_t  row;
    rst          = 1'b1;
    in_valid     = 1'b0;
    page_number  = '0;
    steady_feed  = 1'b0;
    steady_drain = 1'b0;
    clock_hand   = 0;
    hits_so_far     = '0;
    requests_so_far = '0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      resident_page[i] = '0;
      frame_filled[i]  = 1'b0;
      second_chance[i] = 1'b0;
    end

    // Fill all four frames, take a hit, then force sweeps: one that clears
    // a single use bit, one that goes all the way round and returns to
    // where it began, a hand wrap, and the eviction of page zero, which
    // must still report evicted with a zero page.
    opening_rows.push_back('{16'h0000, 1'b1, '{1'b0, 2'd0, 1'b0, 16'h0000, 32'd0, 32'd1}});
    opening_rows.push_back('{16'hFFFF, 1'b1, '{1'b0, 2'd1, 1'b0, 16'h0000, 32'd0, 32'd2}});
    opening_rows.push_back('{16'h0000, 1'b1, '{1'b1, 2'd0, 1'b0, 16'h0000, 32'd1, 32'd3}});
    opening_rows.push_back('{16'h5555, 1'b1, '{1'b0, 2'd2, 1'b0, 16'h0000, 32'd1, 32'd4}});
    opening_rows.push_back('{16'hAAAA, 1'b1, '{1'b0, 2'd3, 1'b0, 16'h0000, 32'd1, 32'd5}});
    opening_rows.push_back('{16'h1234, 1'b1, '{1'b0, 2'd1, 1'b1, 16'hFFFF, 32'd1, 32'd6}});
    opening_rows.push_back('{16'h0000, 1'b1, '{1'b1, 2'd0, 1'b0, 16'h0000, 32'd2, 32'd7}});
    opening_rows.push_back('{16'h1234, 1'b1, '{1'b1, 2'd1, 1'b0, 16'h0000, 32'd3, 32'd8}});
    opening_rows.push_back('{16'h5555, 1'b1, '{1'b1, 2'd2, 1'b0, 16'h0000, 32'd4, 32'd9}});
    opening_rows.push_back('{16'hAAAA, 1'b1, '{1'b1, 2'd3, 1'b0, 16'h0000, 32'd5, 32'd10}});
    opening_rows.push_back('{16'hFFFF, 1'b1, '{1'b0, 2'd2, 1'b1, 16'h5555, 32'd5, 32'd11}});
    opening_rows.push_back('{16'h8001, 1'b1, '{1'b0, 2'd3, 1'b1, 16'hAAAA, 32'd5, 32'd12}});
    opening_rows.push_back('{16'h7FFE, 1'b1, '{1'b0, 2'd0, 1'b1, 16'h0000, 32'd5, 32'd13}});
    opening_rows.push_back('{16'h0001, 1'b1, '{1'b0, 2'd1, 1'b1, 16'h1234, 32'd5, 32'd14}});
    opening_rows.push_back('{16'h0001, 1'b1, '{1'b1, 2'd1, 1'b0, 16'h0000, 32'd6, 32'd15}});
    opening_rows.push_back('{16'hFFFF, 1'b1, '{1'b1, 2'd2, 1'b0, 16'h0000, 32'd7, 32'd16}});
    opening_rows.push_back('{16'hAAAA, 1'b1, '{1'b0, 2'd3, 1'b1, 16'h8001, 32'd7, 32'd17}});
    opening_rows.push_back('{16'h00FF, 1'b0, '0});
    opening_rows.push_back('{16'hFF00, 1'b0, '0});
    opening_rows.push_back('{16'h7FFE, 1'b0, '0});

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (opening_rows[i]) offer_page(opening_rows[i]);

    // Most requests come from a small pool, so the frames stay full and
    // hits mix with evictions; the pool and its span change now and then,
    // and one request in ten is any page at all.
    pool_span = 5;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 150 == 0) begin
        foreach (page_pool[k]) page_pool[k] = PW'($urandom_range(0, 16'hFFFF));
        pool_span = $urandom_range(3, 7);
      end
      if (n % 100 == 0) begin
        steady_feed  = ($urandom_range(0, 3) == 0);
        steady_drain = ($urandom_range(0, 3) == 0);
      end
      row = '0;
      if ($urandom_range(0, 9) == 0) begin
        row.page = PW'($urandom_range(0, 16'hFFFF));
      end else begin
        row.page = page_pool[$urandom_range(0, pool_span)];
      end
      offer_page(row);
    end
    in_valid <= 1'b0;

    while (awaited_lookups.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result side: a random stall before each word, none in steady stretches.
  initial begin : drain
    int stall;
    out_ready    = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = steady_drain ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Every word taken is held against the oldest prediction.
  always @(posedge clk) begin
    lookup_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_lookups.size() == 0) begin
        $display("%0t: result word with nothing awaited", $time);
        mismatches++;
      end else begin
        want = awaited_lookups.pop_front();
        if (hit !== want.hit) begin
          $display("%0t: hit expected %0d, got %0d", $time, want.hit, hit);
          mismatches++;
        end
        if (frame !== want.frame) begin
          $display("%0t: frame expected %0d, got %0d", $time, want.frame, frame);
          mismatches++;
        end
        if (evicted !== want.evicted) begin
          $display("%0t: evicted expected %0d, got %0d", $time, want.evicted, evicted);
          mismatches++;
        end
        if (evicted_page !== want.evicted_page) begin
          $display("%0t: evicted_page expected %h, got %h", $time,
                   want.evicted_page, evicted_page);
          mismatches++;
        end
        if (hit_total !== want.hit_total) begin
          $display("%0t: hit_total expected %0d, got %0d", $time,
                   want.hit_total, hit_total);
          mismatches++;
        end
        if (request_total !== want.request_total) begin
          $display("%0t: request_total expected %0d, got %0d", $time,
                   want.request_total, request_total);
          mismatches++;
        end
      end
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/cpr_pkg.sv
rtl/core/cpr_ctrl.sv
rtl/core/cpr_datapath.sv
rtl/core/clock_page_replacement.sv
bench/tb_clock_page_replacement.sv
